// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== src/tspp_pkg.sv =====
// ----------------------------------------------------------------------------
// tspp_pkg
// Types and constants of the three-axis step pulse positioner.
// ----------------------------------------------------------------------------
package tspp_pkg;

	// Default and limits
	localparam int TSPP_NUM_AXES = 3;
	localparam int OUT_BITS      = 3;
	localparam int CFG_AXES      = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int POS_W         = 32;
	localparam int CNT_W         = 16;

	localparam logic [CNT_W-1:0] DEFAULT_PERIOD   = 16'd999;
	localparam logic [CNT_W-1:0] DEFAULT_PRESCALE = 16'd71;

	// Register map
	localparam int REG_PERIOD_BASE   = 0;
	localparam int REG_PRESCALE_BASE = 3;

	// Request codes
	typedef enum logic [1:0] {
		REQ_MOVE = 2'd0,
		REQ_STOP = 2'd1,
		REQ_TICK = 2'd2,
		REQ_READ = 2'd3
	} req_t;

endpackage

// ===== src/tspp_req_if.sv =====
// ----------------------------------------------------------------------------
// tspp_req_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface tspp_req_if;
	import tspp_pkg::*;

	logic                     valid;
	logic                     ready;
	req_t                     req_type;
	logic [1:0]               axis;
	logic signed [POS_W-1:0]  target_position;

	modport source (output valid, output req_type, output axis, output target_position,
		input ready);
	modport sink (input valid, input req_type, input axis, input target_position,
		output ready);
endinterface

// ===== src/tspp_res_if.sv =====
// ----------------------------------------------------------------------------
// tspp_res_if
// Result channel: valid/ready handshake with status payload.
// ----------------------------------------------------------------------------
interface tspp_res_if;
	import tspp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OUT_BITS-1:0]      step_pins;
	logic [OUT_BITS-1:0]      dir_pins;
	logic [OUT_BITS-1:0]      enable_pins;
	logic [OUT_BITS-1:0]      busy_res;
	logic [OUT_BITS-1:0]      done_res;
	logic signed [POS_W-1:0]  position;

	modport source (output valid, output step_pins, output dir_pins, output enable_pins,
		output busy_res, output done_res, output position, input ready);
	modport sink (input valid, input step_pins, input dir_pins, input enable_pins,
		input busy_res, input done_res, input position, output ready);
endinterface

// ===== src/three_axis_step_pulse_positioner_top.sv =====
// ----------------------------------------------------------------------------
// three_axis_step_pulse_positioner_top
// Step/direction pulse generator with absolute positioning per axis.
// ----------------------------------------------------------------------------
// The request updates the axis state (counters, position, flags) at the
// accepting edge and the status is captured in a single output register, so
// a new request is taken every cycle as long as the result register is empty
// or being drained in that cycle. The per-axis next-state logic uses one
// 32-bit subtract for a move and one 17-bit compare pair for a tick. A tick
// request serves as the timer clock of every running axis; move and stop
// address one axis, read returns status only.
// Period and prescale registers take effect at once; zero acts as one.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_positioner_top #(
	parameter int NUM_AXES = tspp_pkg::TSPP_NUM_AXES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	tspp_req_if.sink                             req,
	tspp_res_if.source                           res,
	input  logic                                 cfg_we,
	input  logic [tspp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tspp_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import tspp_pkg::*;

	logic                 in_xfer;
	logic                 res_valid_q;
	logic [NUM_AXES-1:0]  step_v, dir_v, en_v, busy_v, done_v;
	logic [POS_W-1:0]     pos_sel [NUM_AXES];
	logic [POS_W-1:0]     pos_or;
	logic [OUT_BITS-1:0]  step_o, dir_o, en_o, busy_o, done_o;

	logic [OUT_BITS-1:0]  step_q, dir_q, en_q, busy_q, done_q;
	logic [POS_W-1:0]     pos_q;

	// Take a request whenever the result register is free or being drained
	assign req.ready = !res_valid_q || res.ready;
	assign in_xfer   = req.valid && req.ready;

	// Per-axis timer and position state
	for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
		logic [CNT_W-1:0] period_lim, prescale_lim;
		logic [CNT_W-1:0] eff_per, eff_pre;
		logic [POS_W-1:0] pos_cur_q, pos_n;
		logic [POS_W-1:0] done_cnt_q, done_cnt_n;
		logic [POS_W-1:0] wanted_q, wanted_n;
		logic [CNT_W-1:0] pre_cnt_q, pre_cnt_n;
		logic [CNT_W-1:0] per_cnt_q, per_cnt_n;
		logic             dir_cur_q, dir_n;
		logic             run_q, run_n;
		logic             ena_q, ena_n;
		logic             done_n;
		logic             hit;
		logic [POS_W-1:0] diff;
		logic [POS_W-1:0] done_inc;
		logic [CNT_W:0]   pre_inc, per_inc;

		// Rate registers for axes on the register map, defaults elsewhere
		if (i < CFG_AXES) begin : g_cfg
			logic [CNT_W-1:0] period_q, prescale_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					period_q   <= DEFAULT_PERIOD;
					prescale_q <= DEFAULT_PRESCALE;
				end else if (cfg_we) begin
					if (cfg_index == CFG_IDX_W'(REG_PERIOD_BASE + i))
						period_q <= cfg_data;
					if (cfg_index == CFG_IDX_W'(REG_PRESCALE_BASE + i))
						prescale_q <= cfg_data;
				end
			end

			assign period_lim   = period_q;
			assign prescale_lim = prescale_q;
		end else begin : g_fix
			assign period_lim   = DEFAULT_PERIOD;
			assign prescale_lim = DEFAULT_PRESCALE;
		end

		assign eff_per  = (period_lim == '0) ? CNT_W'(1) : period_lim;
		assign eff_pre  = (prescale_lim == '0) ? CNT_W'(1) : prescale_lim;
		assign hit      = (32'(req.axis) == i);
		assign diff     = POS_W'(req.target_position) - pos_cur_q;
		assign done_inc = done_cnt_q + POS_W'(1);
		assign pre_inc  = {1'b0, pre_cnt_q} + (CNT_W+1)'(1);
		assign per_inc  = {1'b0, per_cnt_q} + (CNT_W+1)'(1);

		// Work out the axis state after this request
		always_comb begin
			pos_n      = pos_cur_q;
			done_cnt_n = done_cnt_q;
			wanted_n   = wanted_q;
			pre_cnt_n  = pre_cnt_q;
			per_cnt_n  = per_cnt_q;
			dir_n      = dir_cur_q;
			run_n      = run_q;
			ena_n      = ena_q;
			done_n     = 1'b0;
			unique case (req.req_type)
				REQ_MOVE: begin
					if (hit && diff != '0) begin
						dir_n      = !diff[POS_W-1];
						wanted_n   = diff[POS_W-1] ? (POS_W'(0) - diff) : diff;
						done_cnt_n = '0;
						pre_cnt_n  = '0;
						per_cnt_n  = '0;
						ena_n      = 1'b1;
						run_n      = 1'b1;
					end
				end
				REQ_STOP: begin
					if (hit) begin
						run_n = 1'b0;
						ena_n = 1'b0;
					end
				end
				REQ_TICK: begin
					if (run_q) begin
						if (pre_inc < {1'b0, eff_pre}) begin
							pre_cnt_n = pre_inc[CNT_W-1:0];
						end else begin
							pre_cnt_n = '0;
							if (per_inc < {1'b0, eff_per}) begin
								per_cnt_n = per_inc[CNT_W-1:0];
							end else begin
								// Period wrap: take one step
								per_cnt_n  = '0;
								done_cnt_n = done_inc;
								pos_n      = dir_cur_q ? (pos_cur_q + POS_W'(1))
									: (pos_cur_q - POS_W'(1));
								if (done_inc >= wanted_q) begin
									run_n  = 1'b0;
									done_n = 1'b1;
								end
							end
						end
					end
				end
				REQ_READ: begin
				end
			endcase
		end

		// Commit the axis state on each request transfer
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pos_cur_q  <= '0;
				done_cnt_q <= '0;
				wanted_q   <= '0;
				pre_cnt_q  <= '0;
				per_cnt_q  <= '0;
				dir_cur_q  <= 1'b1;
				run_q      <= 1'b0;
				ena_q      <= 1'b0;
			end else if (in_xfer) begin
				pos_cur_q  <= pos_n;
				done_cnt_q <= done_cnt_n;
				wanted_q   <= wanted_n;
				pre_cnt_q  <= pre_cnt_n;
				per_cnt_q  <= per_cnt_n;
				dir_cur_q  <= dir_n;
				run_q      <= run_n;
				ena_q      <= ena_n;
			end
		end

		// Status bits as seen after this request
		assign step_v[i]  = run_n && (per_cnt_n < (eff_per >> 1));
		assign dir_v[i]   = dir_n;
		assign en_v[i]    = ena_n;
		assign busy_v[i]  = run_n;
		assign done_v[i]  = done_n;
		assign pos_sel[i] = hit ? pos_n : '0;
	end

	// Pick the addressed axis position, zero if none
	always_comb begin
		pos_or = '0;
		for (int k = 0; k < NUM_AXES; k++)
			pos_or = pos_or | pos_sel[k];
	end

	// Fit the per-axis vectors to the status fields
	for (genvar b = 0; b < OUT_BITS; b++) begin : g_out
		if (b < NUM_AXES) begin : g_live
			assign step_o[b] = step_v[b];
			assign dir_o[b]  = dir_v[b];
			assign en_o[b]   = en_v[b];
			assign busy_o[b] = busy_v[b];
			assign done_o[b] = done_v[b];
		end else begin : g_none
			assign step_o[b] = 1'b0;
			assign dir_o[b]  = 1'b0;
			assign en_o[b]   = 1'b0;
			assign busy_o[b] = 1'b0;
			assign done_o[b] = 1'b0;
		end
	end

	// Result register: load on request transfer, drop on result transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_xfer) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			step_q <= step_o;
			dir_q  <= dir_o;
			en_q   <= en_o;
			busy_q <= busy_o;
			done_q <= done_o;
			pos_q  <= pos_or;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.step_pins   = step_q;
	assign res.dir_pins    = dir_q;
	assign res.enable_pins = en_q;
	assign res.busy_res    = busy_q;
	assign res.done_res    = done_q;
	assign res.position    = pos_q;

endmodule

// ===== src/tspp_checker.sv =====
// ----------------------------------------------------------------------------
// tspp_checker
// Port-level checks of the step pulse positioner, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tspp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tspp_pkg::OUT_BITS-1:0]     step_pins,
	input logic [tspp_pkg::OUT_BITS-1:0]     enable_pins,
	input logic [tspp_pkg::OUT_BITS-1:0]     busy_res,
	input logic [tspp_pkg::OUT_BITS-1:0]     done_res,
	input logic [tspp_pkg::POS_W-1:0]        position
);
	import tspp_pkg::*;

	// A stalled result holds its position
	`ASSERT_NEXT(a_res_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(position))

	// An empty result register never blocks requests
	`ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

	// An axis that just finished is no longer stepping
	`ASSERT_IMP(a_done_not_busy, clk, arst_n, out_valid, (done_res & busy_res) == '0)

	// A stepping axis always has its driver enabled
	`ASSERT_IMP(a_busy_enabled, clk, arst_n, out_valid, (busy_res & ~enable_pins) == '0)

	// Step pulses only come from stepping axes
	`ASSERT_IMP(a_step_busy, clk, arst_n, out_valid, (step_pins & ~busy_res) == '0)

endmodule

bind three_axis_step_pulse_positioner_top tspp_checker u_tspp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (req.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.step_pins   (res.step_pins),
	.enable_pins (res.enable_pins),
	.busy_res    (res.busy_res),
	.done_res    (res.done_res),
	.position    (res.position)
);
